@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the instruction decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

@@ design/rv32d_pkg.sv @@
// Types and constants shared by the RV32I subset instruction decoder.
`timescale 1ns / 1ps

package rv32d_pkg;

    // Major opcodes recognised by the decoder.
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_LUI    = 7'h37;

    // funct3 codes, grouped by opcode.
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_JALR = 3'd0;
    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SW   = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;

    typedef enum logic [2:0] {
        FMT_R       = 3'd0,
        FMT_I       = 3'd1,
        FMT_LOAD    = 3'd2,
        FMT_S       = 3'd3,
        FMT_B       = 3'd4,
        FMT_J       = 3'd5,
        FMT_U       = 3'd6,
        FMT_UNKNOWN = 3'd7
    } format_t;

    typedef enum logic [4:0] {
        MN_ADD     = 5'd0,
        MN_OR      = 5'd1,
        MN_SLT     = 5'd2,
        MN_SLTU    = 5'd3,
        MN_SLL     = 5'd4,
        MN_JALR    = 5'd5,
        MN_ADDI    = 5'd6,
        MN_ORI     = 5'd7,
        MN_LB      = 5'd8,
        MN_LBU     = 5'd9,
        MN_LW      = 5'd10,
        MN_SB      = 5'd11,
        MN_SW      = 5'd12,
        MN_BEQ     = 5'd13,
        MN_BNE     = 5'd14,
        MN_BLT     = 5'd15,
        MN_BGE     = 5'd16,
        MN_JAL     = 5'd17,
        MN_LUI     = 5'd18,
        MN_UNKNOWN = 5'd19
    } mnemonic_t;

    // Decoded item; the first member sits in the highest bits, so the packed
    // word matches the output tdata layout with format in the lowest bits.
    typedef struct packed {
        logic signed [20:0] immediate;
        logic [4:0]         src2_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         dest_reg;
        mnemonic_t          mnemonic;
        format_t            format;
    } decoded_t;

    localparam int DECODED_W = $bits(decoded_t);
    localparam int OUT_TDATA_W = ((DECODED_W + 7) / 8) * 8;

endpackage

@@ design/rv32d_decode.sv @@
// Combinational decode of one RV32I instruction word into its fields.
`timescale 1ns / 1ps

module rv32d_decode (
    input  logic [31:0]         instr,
    output rv32d_pkg::decoded_t decoded
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [20:0] imm_i;
    logic [20:0] imm_s;
    logic [20:0] imm_b;
    logic [20:0] imm_j;
    logic [20:0] imm_u;

    assign opc = instr[6:0];
    assign f3  = instr[14:12];
    assign rd  = instr[11:7];
    assign rs1 = instr[19:15];
    assign rs2 = instr[24:20];

    assign imm_i = {{9{instr[31]}}, instr[31:20]};
    assign imm_s = {{9{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b = {{8{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_j = {instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
    assign imm_u = {1'b0, instr[31:12]};

    always_comb
    begin
        decoded           = '0;
        decoded.format    = rv32d_pkg::FMT_UNKNOWN;
        decoded.mnemonic  = rv32d_pkg::MN_UNKNOWN;
        unique case (opc)
            rv32d_pkg::OPC_OP:
            begin
                decoded.format   = rv32d_pkg::FMT_R;
                decoded.dest_reg = rd;
                decoded.src1_reg = rs1;
                decoded.src2_reg = rs2;
                unique case (f3)
                    rv32d_pkg::F3_ADD:  decoded.mnemonic = rv32d_pkg::MN_ADD;
                    rv32d_pkg::F3_OR:   decoded.mnemonic = rv32d_pkg::MN_OR;
                    rv32d_pkg::F3_SLT:  decoded.mnemonic = rv32d_pkg::MN_SLT;
                    rv32d_pkg::F3_SLTU: decoded.mnemonic = rv32d_pkg::MN_SLTU;
                    rv32d_pkg::F3_SLL:  decoded.mnemonic = rv32d_pkg::MN_SLL;
                    default:            decoded.mnemonic = rv32d_pkg::MN_UNKNOWN;
                endcase
            end
            rv32d_pkg::OPC_JALR:
            begin
                decoded.format    = rv32d_pkg::FMT_I;
                decoded.dest_reg  = rd;
                decoded.src1_reg  = rs1;
                decoded.immediate = imm_i;
                if (f3 == rv32d_pkg::F3_JALR)
                begin
                    decoded.mnemonic = rv32d_pkg::MN_JALR;
                end
            end
            rv32d_pkg::OPC_OP_IMM:
            begin
                decoded.format    = rv32d_pkg::FMT_I;
                decoded.dest_reg  = rd;
                decoded.src1_reg  = rs1;
                decoded.immediate = imm_i;
                unique case (f3)
                    rv32d_pkg::F3_ADD: decoded.mnemonic = rv32d_pkg::MN_ADDI;
                    rv32d_pkg::F3_OR:  decoded.mnemonic = rv32d_pkg::MN_ORI;
                    default:           decoded.mnemonic = rv32d_pkg::MN_UNKNOWN;
                endcase
            end
            rv32d_pkg::OPC_LOAD:
            begin
                decoded.format    = rv32d_pkg::FMT_LOAD;
                decoded.dest_reg  = rd;
                decoded.src1_reg  = rs1;
                decoded.immediate = imm_i;
                unique case (f3)
                    rv32d_pkg::F3_LB:  decoded.mnemonic = rv32d_pkg::MN_LB;
                    rv32d_pkg::F3_LBU: decoded.mnemonic = rv32d_pkg::MN_LBU;
                    rv32d_pkg::F3_LW:  decoded.mnemonic = rv32d_pkg::MN_LW;
                    default:           decoded.mnemonic = rv32d_pkg::MN_UNKNOWN;
                endcase
            end
            rv32d_pkg::OPC_STORE:
            begin
                decoded.format    = rv32d_pkg::FMT_S;
                decoded.src1_reg  = rs1;
                decoded.src2_reg  = rs2;
                decoded.immediate = imm_s;
                unique case (f3)
                    rv32d_pkg::F3_SB: decoded.mnemonic = rv32d_pkg::MN_SB;
                    rv32d_pkg::F3_SW: decoded.mnemonic = rv32d_pkg::MN_SW;
                    default:          decoded.mnemonic = rv32d_pkg::MN_UNKNOWN;
                endcase
            end
            rv32d_pkg::OPC_BRANCH:
            begin
                decoded.format    = rv32d_pkg::FMT_B;
                decoded.src1_reg  = rs1;
                decoded.src2_reg  = rs2;
                decoded.immediate = imm_b;
                unique case (f3)
                    rv32d_pkg::F3_BEQ: decoded.mnemonic = rv32d_pkg::MN_BEQ;
                    rv32d_pkg::F3_BNE: decoded.mnemonic = rv32d_pkg::MN_BNE;
                    rv32d_pkg::F3_BLT: decoded.mnemonic = rv32d_pkg::MN_BLT;
                    rv32d_pkg::F3_BGE: decoded.mnemonic = rv32d_pkg::MN_BGE;
                    default:           decoded.mnemonic = rv32d_pkg::MN_UNKNOWN;
                endcase
            end
            rv32d_pkg::OPC_JAL:
            begin
                decoded.format    = rv32d_pkg::FMT_J;
                decoded.mnemonic  = rv32d_pkg::MN_JAL;
                decoded.dest_reg  = rd;
                decoded.immediate = imm_j;
            end
            rv32d_pkg::OPC_LUI:
            begin
                decoded.format    = rv32d_pkg::FMT_U;
                decoded.mnemonic  = rv32d_pkg::MN_LUI;
                decoded.dest_reg  = rd;
                decoded.immediate = imm_u;
            end
            default:
            begin
                decoded.format   = rv32d_pkg::FMT_UNKNOWN;
                decoded.mnemonic = rv32d_pkg::MN_UNKNOWN;
            end
        endcase
    end

endmodule

@@ design/rv32i_subset_instruction_decoder.sv @@
// Top level of the RV32I subset instruction decoder: input register, decode, result register.
`timescale 1ns / 1ps

// The decoder takes one 32-bit instruction word per item on the slave stream
// (s_tvalid, s_tready, s_tdata) and returns one decoded item per word on the
// master stream (m_tvalid, m_tready, m_tdata). An item moves on a rising edge
// at which its tvalid and tready are both high.
// Each word is captured in an input register; the decode is a short block of
// combinational logic from that register into the result register, which
// drives the master stream. A result passes from the input register to the
// result register and leaves from there, and the block accepts one item in
// every cycle while the receiver is ready.
// Each stage takes a new item whenever it is empty or its item leaves in the
// same cycle, so when the receiver stalls the result register holds its item
// steady and the input register fills; s_tready falls only once both stages
// are occupied, and nothing is lost or repeated.
// Reset (rst_n low, asynchronous) empties both stages; payload registers keep
// whatever they held, as their contents are ignored while not valid.
// Words with an unrecognised opcode give format 7 and the unknown mnemonic with
// every other field zero; an unlisted funct3 gives the unknown mnemonic while
// the fields of that format are still decoded.

module rv32i_subset_instruction_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] instr
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] format, [7:3] mnemonic, [12:8] dest_reg, [17:13] src1_reg,
    // [22:18] src2_reg, [43:23] immediate, [47:44] zero
    output logic [rv32d_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [31:0]         instr_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    rv32d_pkg::decoded_t result_reg;
    rv32d_pkg::decoded_t decoded;
    logic                out_load;
    logic                in_load;

    // The result stage can take an item when empty or when its item leaves now.
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    assign in_valid_next  = in_load || (in_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    rv32d_decode u_decode (
        .instr   (instr_reg),
        .decoded (decoded)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            instr_reg <= s_tdata;
        end
        if (out_load)
        begin
            result_reg <= decoded;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rv32d_pkg::OUT_TDATA_W - rv32d_pkg::DECODED_W){1'b0}}, result_reg};

endmodule

@@ design/rv32d_checker.sv @@
// Port-level assertion checker for the instruction decoder, with its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rv32d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [rv32d_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic [2:0] fmt;
    logic [4:0] mn;
    logic       is_unknown;
    logic       unknown_clear;
    logic       is_branch_jump;

    assign fmt = m_tdata[2:0];
    assign mn  = m_tdata[7:3];

    assign is_unknown     = m_tvalid && fmt == rv32d_pkg::FMT_UNKNOWN;
    assign unknown_clear  = mn == rv32d_pkg::MN_UNKNOWN
                            && m_tdata[rv32d_pkg::OUT_TDATA_W-1:8] == '0;
    assign is_branch_jump = m_tvalid
                            && (fmt == rv32d_pkg::FMT_B || fmt == rv32d_pkg::FMT_J);

    // A stalled result stays on the bus unchanged.
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // An accepted word is output via both registers if the receiver is ready.
    `ASSERT_NEXT(a_latency, clk, rst_n, (s_tvalid && s_tready) ##1 m_tready, m_tvalid)

    // Unrecognised opcodes carry the unknown mnemonic and no other fields.
    `ASSERT_IMPLIES(a_unknown_clear, clk, rst_n, is_unknown, unknown_clear)

    // Branch and jump offsets are always even.
    `ASSERT_IMPLIES(a_offset_even, clk, rst_n, is_branch_jump, !m_tdata[23])

endmodule

bind rv32i_subset_instruction_decoder rv32d_checker u_rv32d_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/decode_checker.sv @@
// Stream monitor that predicts each decoded item and compares it with the decoder's output.
`timescale 1ns / 1ps

module decode_checker
    import rv32d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [31:0]            s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic [31:0] word;
        decoded_t    fields;
    } queued_decode_t;

    queued_decode_t pending_decodes[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Decode of one instruction word at the output widths.
    function automatic decoded_t decode_word(input logic [31:0] w);
        decoded_t d;
        logic [2:0] f3;
        f3         = w[14:12];
        d          = '0;
        d.format   = FMT_UNKNOWN;
        d.mnemonic = MN_UNKNOWN;
        case (w[6:0])
            OPC_OP:
            begin
                d.format   = FMT_R;
                d.dest_reg = w[11:7];
                d.src1_reg = w[19:15];
                d.src2_reg = w[24:20];
                case (f3)
                    F3_ADD:  d.mnemonic = MN_ADD;
                    F3_OR:   d.mnemonic = MN_OR;
                    F3_SLT:  d.mnemonic = MN_SLT;
                    F3_SLTU: d.mnemonic = MN_SLTU;
                    F3_SLL:  d.mnemonic = MN_SLL;
                    default: d.mnemonic = MN_UNKNOWN;
                endcase
            end
            OPC_JALR, OPC_OP_IMM:
            begin
                d.format    = FMT_I;
                d.dest_reg  = w[11:7];
                d.src1_reg  = w[19:15];
                d.immediate = {{9{w[31]}}, w[31:20]};
                if (w[6:0] == OPC_JALR && f3 == F3_JALR)
                    d.mnemonic = MN_JALR;
                else if (w[6:0] == OPC_OP_IMM && f3 == F3_ADD)
                    d.mnemonic = MN_ADDI;
                else if (w[6:0] == OPC_OP_IMM && f3 == F3_OR)
                    d.mnemonic = MN_ORI;
            end
            OPC_LOAD:
            begin
                d.format    = FMT_LOAD;
                d.dest_reg  = w[11:7];
                d.src1_reg  = w[19:15];
                d.immediate = {{9{w[31]}}, w[31:20]};
                case (f3)
                    F3_LB:   d.mnemonic = MN_LB;
                    F3_LBU:  d.mnemonic = MN_LBU;
                    F3_LW:   d.mnemonic = MN_LW;
                    default: d.mnemonic = MN_UNKNOWN;
                endcase
            end
            OPC_STORE:
            begin
                d.format    = FMT_S;
                d.src1_reg  = w[19:15];
                d.src2_reg  = w[24:20];
                d.immediate = {{9{w[31]}}, w[31:25], w[11:7]};
                case (f3)
                    F3_SB:   d.mnemonic = MN_SB;
                    F3_SW:   d.mnemonic = MN_SW;
                    default: d.mnemonic = MN_UNKNOWN;
                endcase
            end
            OPC_BRANCH:
            begin
                d.format    = FMT_B;
                d.src1_reg  = w[19:15];
                d.src2_reg  = w[24:20];
                d.immediate = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                case (f3)
                    F3_BEQ:  d.mnemonic = MN_BEQ;
                    F3_BNE:  d.mnemonic = MN_BNE;
                    F3_BLT:  d.mnemonic = MN_BLT;
                    F3_BGE:  d.mnemonic = MN_BGE;
                    default: d.mnemonic = MN_UNKNOWN;
                endcase
            end
            OPC_JAL:
            begin
                d.format    = FMT_J;
                d.mnemonic  = MN_JAL;
                d.dest_reg  = w[11:7];
                d.immediate = {w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            OPC_LUI:
            begin
                d.format    = FMT_U;
                d.mnemonic  = MN_LUI;
                d.dest_reg  = w[11:7];
                d.immediate = {1'b0, w[31:12]};
            end
            default:
            begin
            end
        endcase
        return d;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("decode mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic check_field(input logic [31:0] word, input string name,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("instr %08h %s: got %0h, expected %0h",
                                      word, name, got, want));
    endtask

    always @(posedge clk)
    begin : monitor
        queued_decode_t head;
        decoded_t       got;
        if (rst_n)
        begin
            // The result side is handled first: an item accepted at this edge
            // cannot leave at the same edge.
            if (m_tvalid && m_tready)
            begin
                got = decoded_t'(m_tdata[DECODED_W-1:0]);
                if (pending_decodes.size() == 0)
                    report_mismatch($sformatf("result %0h with no instruction waiting",
                                              m_tdata));
                else
                begin
                    head = pending_decodes.pop_front();
                    check_field(head.word, "format", 32'(got.format),
                                32'(head.fields.format));
                    check_field(head.word, "mnemonic", 32'(got.mnemonic),
                                32'(head.fields.mnemonic));
                    check_field(head.word, "dest_reg", 32'(got.dest_reg),
                                32'(head.fields.dest_reg));
                    check_field(head.word, "src1_reg", 32'(got.src1_reg),
                                32'(head.fields.src1_reg));
                    check_field(head.word, "src2_reg", 32'(got.src2_reg),
                                32'(head.fields.src2_reg));
                    check_field(head.word, "immediate", 32'(got.immediate),
                                32'(head.fields.immediate));
                    check_field(head.word, "padding",
                                32'(m_tdata[OUT_TDATA_W-1:DECODED_W]), 32'd0);
                end
            end
            if (s_tvalid && s_tready)
                pending_decodes.push_back('{word: s_tdata, fields: decode_word(s_tdata)});
            pending = pending_decodes.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Top of the decoder testbench: clock, reset, stimulus, back-pressure and the verdict.
`timescale 1ns / 1ps

// The top drives instruction words into the slave stream and back-pressure
// into the master stream, both at the falling edge, while the checker beside
// the block samples both streams at the rising edge and compares every
// decoded item with its own prediction. A short directed list comes first,
// then three random phases that differ in how often each side idles.
module tb;
    import rv32d_pkg::*;

    localparam int RESET_CYCLES     = 12;
    localparam int RANDOM_PER_PHASE = 417;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 8;
    localparam int CYCLE_LIMIT      = 200000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [31:0]            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_requests;
    int   cycle_count;

    rv32i_subset_instruction_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    decode_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a correct run finishes far inside this limit, even
    // with the heaviest idling on both sides and the long hold-off.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Receiver. Each new hold-off request makes it refuse results for a long
    // stretch, counted here, so that both stages of the block fill and
    // s_tready drops while the sender keeps offering items. Requests are
    // counted up by the stimulus just after a rising edge, so a new one is
    // always seen at the next falling edge.
    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offers one item and returns at the falling edge after its acceptance.
    // It is entered at a falling edge before anything has been assigned in
    // that step, so s_tvalid gets exactly one assignment per step.
    task automatic send_item(input logic [31:0] word);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [31:0] directed_words[$];
        logic [6:0]  known_opcodes[8];
        logic [31:0] word;
        int          pick;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 35;
        recv_idle_pct = 87;
        hold_requests = 0;

        known_opcodes = '{OPC_OP, OPC_JALR, OPC_OP_IMM, OPC_LOAD,
                          OPC_STORE, OPC_BRANCH, OPC_JAL, OPC_LUI};

        // Directed words: every mnemonic, an unlisted funct3 in each format
        // that has one, jalr with a non-zero funct3, unrecognised opcodes,
        // and the extremes of each immediate encoding. funct7 is set to
        // non-zero values in places to show that it is ignored.
        directed_words = '{
            32'h0000_0000,
            32'hffff_ffff,
            {7'h00, 5'd31, 5'd0, F3_ADD, 5'd31, OPC_OP},
            {7'h7f, 5'd0, 5'd31, F3_OR, 5'd0, OPC_OP},
            {7'h20, 5'd3, 5'd2, F3_SLT, 5'd1, OPC_OP},
            {7'h00, 5'd6, 5'd5, F3_SLTU, 5'd4, OPC_OP},
            {7'h00, 5'd9, 5'd8, F3_SLL, 5'd7, OPC_OP},
            {7'h7f, 5'd31, 5'd31, 3'd7, 5'd31, OPC_OP},
            {12'h7ff, 5'd31, F3_JALR, 5'd1, OPC_JALR},
            {12'h800, 5'd1, 3'd1, 5'd31, OPC_JALR},
            {12'h800, 5'd0, F3_ADD, 5'd31, OPC_OP_IMM},
            {12'hfff, 5'd17, F3_OR, 5'd18, OPC_OP_IMM},
            {12'h7ff, 5'd10, 3'd1, 5'd11, OPC_OP_IMM},
            {12'h000, 5'd2, F3_LB, 5'd3, OPC_LOAD},
            {12'h800, 5'd31, F3_LBU, 5'd0, OPC_LOAD},
            {12'h7ff, 5'd4, F3_LW, 5'd5, OPC_LOAD},
            {12'hfff, 5'd6, 3'd7, 5'd7, OPC_LOAD},
            {7'h40, 5'd31, 5'd0, F3_SB, 5'd0, OPC_STORE},
            {7'h3f, 5'd0, 5'd31, F3_SW, 5'd31, OPC_STORE},
            {7'h7f, 5'd1, 5'd2, 3'd1, 5'd31, OPC_STORE},
            {1'b1, 6'h00, 5'd1, 5'd2, F3_BEQ, 4'h0, 1'b0, OPC_BRANCH},
            {1'b0, 6'h3f, 5'd31, 5'd31, F3_BNE, 4'hf, 1'b1, OPC_BRANCH},
            {1'b1, 6'h3f, 5'd7, 5'd8, F3_BLT, 4'hf, 1'b1, OPC_BRANCH},
            {1'b0, 6'h00, 5'd9, 5'd10, F3_BGE, 4'h0, 1'b0, OPC_BRANCH},
            {1'b1, 6'h15, 5'd11, 5'd12, 3'd2, 4'h5, 1'b0, OPC_BRANCH},
            {1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL},
            {1'b0, 10'h3ff, 1'b1, 8'hff, 5'd31, OPC_JAL},
            {20'hfffff, 5'd31, OPC_LUI}
        };

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_words[i])
            send_item(directed_words[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            // Idling settings change just after a rising edge, so that the
            // receiver never reads them in the step in which they change.
            s_tvalid <= 1'b0;
            @(posedge clk);
            case (phase)
                0:
                begin
                    send_idle_pct = 35;
                    recv_idle_pct = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct = 35;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_requests++;
                end
            endcase
            @(negedge clk);

            // Mostly well-formed words with random register, funct3, funct7
            // and immediate bits; the rest are near misses of a known opcode
            // and wholly random words.
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                word = $urandom();
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    word[6:0] = known_opcodes[$urandom_range(0, 7)];
                else if (pick < 93)
                    word[6:0] = known_opcodes[$urandom_range(0, 7)]
                                ^ (7'd1 << $urandom_range(0, 6));
                send_item(word);
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
